>>> src/aiwe_pkg.sv
// Package: shared types, opcodes and control codes for the A32 instruction encoder.
`timescale 1ns / 1ps
`default_nettype none
package aiwe_pkg;

  localparam logic [3:0] OP_DP_IMM = 4'd0;
  localparam logic [3:0] OP_DP_REG = 4'd1;
  localparam logic [3:0] OP_SHIFT  = 4'd2;
  localparam logic [3:0] OP_MOVW   = 4'd3;
  localparam logic [3:0] OP_MOVT   = 4'd4;
  localparam logic [3:0] OP_LDST   = 4'd5;
  localparam logic [3:0] OP_BRANCH = 4'd6;
  localparam logic [3:0] OP_BX     = 4'd7;
  localparam logic [3:0] OP_MUL    = 4'd8;
  localparam logic [3:0] OP_SWI    = 4'd9;

  localparam logic [3:0] ALU_SUB = 4'd2;
  localparam logic [3:0] ALU_ADD = 4'd4;
  localparam logic [3:0] ALU_MOV = 4'd13;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  typedef struct packed {
    logic [3:0]         op;
    logic [3:0]         cond;
    logic [3:0]         alu_op;
    logic               set_flags;
    logic [3:0]         rd;
    logic [3:0]         rn;
    logic [3:0]         rm;
    logic [3:0]         rs;
    logic signed [31:0] imm;
    logic               variant;
    logic               byte_access;
  } in_t;

  typedef struct packed {
    logic [31:0] word;
    logic        error;
  } out_t;

  // Status of the rotation search unit
  typedef struct packed {
    logic done;
    logic fit;
  } rot_sts_t;

endpackage
`default_nettype wire

>>> src/arm_instruction_word_encoder_top.sv
// Top level: A32 instruction word encoder with request/result channels.
// Usage:
//   Input channel in_valid/in_stall/in_data carries one encode request.
//   A request is taken when in_valid is high and in_stall is low. The block
//   holds in_stall high while a request is in work.
//   Output channel out_valid/out_stall/out_data returns one transaction per
//   request: the 32-bit word and an error flag (word is zero on error).
// Operation:
//   The result register loads once a non-immediate request is in work and
//   the output register is free; requests are taken one at a time.
//   Data-processing immediates whose magnitude is above 255 run the
//   rotation search, which strips one zero bit pair per cycle (up to 15)
//   before the result register loads.
//   A new request may be taken while the previous result waits at the
//   output register.
// Reset:
//   rst_n low (synchronous) empties the block; no result is pending.
// Stall:
//   While out_stall is high a pending result holds in the register; a
//   finished request waits in work until the register drains.
`timescale 1ns / 1ps
`default_nettype none
module arm_instruction_word_encoder_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire aiwe_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output aiwe_pkg::out_t      out_data
);
  import aiwe_pkg::*;

  logic        state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;
  in_t         req_r, req_nxt;
  logic        accept;
  logic        in_neg;
  logic [31:0] in_mag;
  rot_sts_t    rot_sts;
  logic [11:0] rot_field;
  logic        neg;
  logic [31:0] mag;
  logic [31:0] br_off;
  logic [3:0]  alu_eff;
  logic        err;
  logic [31:0] word;
  logic        work_done;
  logic        slot_free;
  logic        load_out;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r == ST_BUSY);
  assign in_neg   = in_data.imm[31];
  assign in_mag   = in_neg ? (32'd0 - 32'(in_data.imm)) : 32'(in_data.imm);

  aiwe_rot_unit u_rot (
    .clk   (clk),
    .start (accept),
    .value (in_mag),
    .sts   (rot_sts),
    .field (rot_field)
  );

  assign neg    = req_r.imm[31];
  assign mag    = neg ? (32'd0 - 32'(req_r.imm)) : 32'(req_r.imm);
  assign br_off = 32'(req_r.imm) - 32'd8;

  always_comb begin
    err     = 1'b0;
    word    = 32'd0;
    alu_eff = req_r.alu_op;
    case (req_r.op)
      OP_DP_IMM: begin
        if (neg) begin
          if (req_r.alu_op == ALU_ADD) alu_eff = ALU_SUB;
          else                         err = 1'b1;
        end
        if (!rot_sts.fit) err = 1'b1;
        word = {req_r.cond, 3'b001, alu_eff, req_r.set_flags, req_r.rn, req_r.rd,
                rot_field};
      end
      OP_DP_REG: word = {req_r.cond, 3'b000, req_r.alu_op, req_r.set_flags,
                         req_r.rn, req_r.rd, 8'h00, req_r.rm};
      OP_SHIFT:  word = {req_r.cond, 3'b000, ALU_MOV, 1'b0, 4'h0, req_r.rd,
                         req_r.rs, 2'b00, req_r.variant, 1'b1, req_r.rm};
      OP_MOVW:   word = {req_r.cond, 8'h30, req_r.imm[15:12], req_r.rd,
                         req_r.imm[11:0]};
      OP_MOVT:   word = {req_r.cond, 8'h34, req_r.imm[31:28], req_r.rd,
                         req_r.imm[27:16]};
      // U bit clears for a negative offset
      OP_LDST:   word = {req_r.cond, 4'b0101, !neg, req_r.byte_access, 1'b0,
                         req_r.variant, req_r.rn, req_r.rd, mag[11:0]};
      OP_BRANCH: word = {req_r.cond, 3'b101, req_r.variant, br_off[25:2]};
      OP_BX:     word = {req_r.cond, 8'h12, 4'hF, 4'hF, 4'hF, 2'b00, req_r.variant,
                         1'b1, req_r.rm};
      OP_MUL:    word = {req_r.cond, 8'h00, req_r.rd, 4'h0, req_r.rs, 4'h9, req_r.rm};
      OP_SWI:    word = {req_r.cond, 8'hF0, 20'h00000};
      default:   err = 1'b1;
    endcase
    if (err) word = 32'd0;
  end

  assign work_done = (req_r.op != OP_DP_IMM) || rot_sts.done;
  assign slot_free = !out_valid_r || !out_stall;
  assign load_out  = (state_r == ST_BUSY) && work_done && slot_free;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt   = in_data;
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (load_out) begin
          out_valid_nxt      = 1'b1;
          out_data_nxt.word  = word;
          out_data_nxt.error = err;
          state_nxt          = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_BUSY))
    else $error("accepted request did not enter work");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.error) |-> (out_data_r.word == 32'd0))
    else $error("error result carries a nonzero word");

  a_fast_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUSY && !out_valid_r && req_r.op != OP_DP_IMM)
      |=> (state_r == ST_IDLE && out_valid_r))
    else $error("non-immediate request not finished in one work cycle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending transaction");

endmodule
`default_nettype wire

>>> src/aiwe_rot_unit.sv
// Iterative rotated-immediate search: strips one zero bit pair per cycle.
`timescale 1ns / 1ps
`default_nettype none
module aiwe_rot_unit (
  input  wire logic              clk,
  input  wire logic              start,
  input  wire logic [31:0]       value,
  output aiwe_pkg::rot_sts_t     sts,
  output logic [11:0]            field
);
  import aiwe_pkg::*;

  logic [31:0] v_r, v_nxt;
  logic [3:0]  k_r, k_nxt;
  logic        fits8;

  assign fits8    = (v_r <= 32'd255);
  assign sts.fit  = fits8;
  // a value above 255 keeps stripping until its low pair is nonzero
  assign sts.done = (fits8 && (k_r == 4'd0)) || (v_r[1:0] != 2'b00);
  // rotate field is (16 - shifts) mod 16; zero when no shift was taken
  assign field    = {4'(4'd0 - k_r), v_r[7:0]};

  always_comb begin
    v_nxt = v_r;
    k_nxt = k_r;
    if (start) begin
      v_nxt = value;
      k_nxt = 4'd0;
    end else if (!sts.done) begin
      v_nxt = {2'b00, v_r[31:2]};
      k_nxt = k_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    k_r <= k_nxt;
  end

endmodule
`default_nettype wire

>>> tb/tb.sv
// Testbench for the A32 instruction word encoder: random and directed requests, scoreboard check.
`timescale 1ns / 1ps
module tb;
  import aiwe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned CHUNK_ITEMS = 500;
  localparam int unsigned NUM_CHUNKS = 3;
  localparam int unsigned TAIL_CYCLES = 40;

  localparam logic [3:0] ALU_MVN = 4'd15;
  localparam logic [3:0] OP_UNUSED_LO = 4'd10;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;
  localparam logic [3:0] COND_AL = 4'd14;
  localparam logic [3:0] COND_NV = 4'd15;
  localparam logic [3:0] COND_EQ = 4'd0;

  localparam logic [7:0] OPC_MOVW = 8'd48;
  localparam logic [7:0] OPC_MOVT = 8'd52;
  localparam logic [7:0] OPC_B = 8'd160;
  localparam logic [7:0] OPC_BL = 8'd176;
  localparam logic [7:0] OPC_BX = 8'd18;
  localparam logic [7:0] OPC_SWI = 8'd240;
  localparam logic [3:0] MUL_TAG = 4'h9;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  in_t pending_reqs[$];
  out_t expected_words[$];
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_fail = 0;
  logic [31:0] cycles = '0;
  logic quiet;

  bit req_taken = 1'b0;
  bit req_out = 1'b0;
  int req_gap = 0;
  int stall_left = 0;

  arm_instruction_word_encoder_top u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one window in four runs with no idling on either side
  assign quiet = (cycles[11:10] == 2'b11);

  function automatic logic [31:0] pack_a32(logic [3:0] cond, logic [7:0] opc, logic [3:0] rn,
                                           logic [3:0] rd, logic [11:0] low);
    return {cond, opc, rn, rd, low};
  endfunction

  function automatic out_t encode_a32(in_t r);
    out_t res;
    logic [31:0] imm_u;
    logic [31:0] mag;
    logic [31:0] v;
    logic [31:0] br;
    logic [4:0] rot;
    logic [3:0] alu;
    logic neg;
    logic fail;
    imm_u = r.imm;
    neg = imm_u[31];
    mag = neg ? (32'd0 - imm_u) : imm_u;
    alu = r.alu_op;
    fail = 1'b0;
    res.word = '0;
    case (r.op)
      OP_DP_IMM: begin
        if (neg) begin
          if (alu == ALU_ADD) alu = ALU_SUB;
          else fail = 1'b1;
        end
        // strip zero bit pairs only from the bottom; no wrap-around search
        v = mag;
        rot = 5'd0;
        if (v > 32'd255) begin
          rot = 5'd16;
          while (v[1:0] == 2'b00 && v != 32'd0) begin
            v = v >> 2;
            rot = rot - 5'd1;
          end
          if (v > 32'd255) fail = 1'b1;
        end
        res.word = pack_a32(r.cond, {3'b001, alu, r.set_flags}, r.rn, r.rd, {rot[3:0], v[7:0]});
      end
      OP_DP_REG:
        res.word = pack_a32(r.cond, {3'b000, r.alu_op, r.set_flags}, r.rn, r.rd, {8'd0, r.rm});
      OP_SHIFT:
        res.word = pack_a32(r.cond, {3'b000, ALU_MOV, 1'b0}, 4'd0, r.rd,
                            {r.rs, 2'b00, r.variant, 1'b1, r.rm});
      OP_MOVW:
        res.word = pack_a32(r.cond, OPC_MOVW, imm_u[15:12], r.rd, imm_u[11:0]);
      OP_MOVT:
        res.word = pack_a32(r.cond, OPC_MOVT, imm_u[31:28], r.rd, imm_u[27:16]);
      OP_LDST:
        // U bit clear for a negative offset; magnitude wraps to 12 bits
        res.word = pack_a32(r.cond, {4'b0101, ~neg, r.byte_access, 1'b0, r.variant}, r.rn, r.rd,
                            mag[11:0]);
      OP_BRANCH: begin
        br = imm_u - 32'd8;
        res.word = pack_a32(r.cond, (r.variant ? OPC_BL : OPC_B), 4'd0, 4'd0, 12'd0)
                 + {8'd0, br[25:2]};
      end
      OP_BX:
        res.word = pack_a32(r.cond, OPC_BX, 4'hF, 4'hF, {4'hF, 2'b00, r.variant, 1'b1, r.rm});
      OP_MUL:
        res.word = pack_a32(r.cond, 8'd0, r.rd, 4'd0, {r.rs, MUL_TAG, r.rm});
      OP_SWI:
        res.word = pack_a32(r.cond, OPC_SWI, 4'd0, 4'd0, 12'd0);
      default:
        fail = 1'b1;
    endcase
    if (fail) res.word = '0;
    res.error = fail;
    return res;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic in_t rand_req();
    in_t r;
    int p;
    logic [31:0] v;
    p = $urandom_range(0, 99);
    if (p < 30) r.op = OP_DP_IMM;
    else if (p < 95) r.op = 4'($urandom_range(OP_DP_REG, OP_SWI));
    else r.op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    r.cond = 4'($urandom_range(0, 15));
    r.alu_op = 4'($urandom_range(0, 15));
    r.set_flags = 1'($urandom_range(0, 1));
    r.rd = 4'($urandom_range(0, 15));
    r.rn = 4'($urandom_range(0, 15));
    r.rm = 4'($urandom_range(0, 15));
    r.rs = 4'($urandom_range(0, 15));
    r.variant = 1'($urandom_range(0, 1));
    r.byte_access = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = 32'($urandom_range(0, 255)) << (2 * $urandom_range(0, 12));
      2: v = 32'($urandom_range(0, 255)) << $urandom_range(0, 24);
      default: v = 32'($urandom_range(0, 8192)) - 32'd4096;
    endcase
    if ($urandom_range(0, 3) == 0) v = 32'd0 - v;
    r.imm = v;
    if (r.op == OP_DP_IMM && v[31] && $urandom_range(0, 1) == 1) r.alu_op = ALU_ADD;
    return r;
  endfunction

  task automatic add_req(logic [3:0] op, logic [3:0] cond, logic [3:0] alu, logic [31:0] imm,
                         logic var_b, logic byt);
    in_t r;
    r = rand_req();
    r.op = op;
    r.cond = cond;
    r.alu_op = alu;
    r.imm = imm;
    r.variant = var_b;
    r.byte_access = byt;
    pending_reqs.push_back(r);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || expected_words.size() != 0) @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (req_taken) begin
        req_taken = 1'b0;
        req_out = 1'b0;
        req_gap = quiet ? 0 : pick_gap();
      end
      if (!req_out) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (pending_reqs.size() != 0) begin
          in_data <= pending_reqs.pop_front();
          req_out = 1'b1;
        end
      end
      in_valid <= req_out;
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  task automatic note_mismatch(string what, out_t want, out_t got);
    n_fail++;
    if (n_fail <= 10)
      $display("%0s: got word %08h err %0b, expected word %08h err %0b", what, got.word,
               got.error, want.word, want.error);
  endtask

  // monitor and scoreboard
  always @(posedge clk) begin : monitor
    out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          want = '0;
          note_mismatch("unexpected transaction", want, out_data);
        end else begin
          want = expected_words.pop_front();
          if (out_data.word !== want.word || out_data.error !== want.error)
            note_mismatch("mismatch", want, out_data);
        end
      end
      if (in_valid && !in_stall) begin
        expected_words.push_back(encode_a32(in_data));
        req_taken = 1'b1;
        n_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 32'd1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;

    // immediate reduction: zero, 8-bit max, rotated, unencodable, negative add/sub
    add_req(OP_DP_IMM, COND_AL, ALU_MOV, 32'd0, 1'b0, 1'b0);
    add_req(OP_DP_IMM, COND_EQ, ALU_ADD, 32'd255, 1'b0, 1'b0);
    add_req(OP_DP_IMM, COND_AL, ALU_MOV, 32'd256, 1'b0, 1'b0);
    add_req(OP_DP_IMM, COND_AL, ALU_SUB, 32'h0000_03FC, 1'b0, 1'b0);
    add_req(OP_DP_IMM, COND_AL, ALU_MOV, 32'h0000_0101, 1'b0, 1'b0);
    add_req(OP_DP_IMM, COND_AL, ALU_MOV, 32'h7F80_0000, 1'b0, 1'b0);
    add_req(OP_DP_IMM, COND_AL, ALU_MOV, 32'h7FFF_FFFF, 1'b0, 1'b0);
    add_req(OP_DP_IMM, COND_AL, ALU_ADD, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_req(OP_DP_IMM, COND_AL, ALU_ADD, 32'h8000_0000, 1'b0, 1'b0);
    add_req(OP_DP_IMM, COND_AL, ALU_SUB, 32'hFFFF_FFFB, 1'b0, 1'b0);
    add_req(OP_DP_REG, COND_NV, ALU_MVN, 32'h1234_5678, 1'b0, 1'b0);
    add_req(OP_SHIFT, COND_AL, ALU_MOV, 32'd0, 1'b0, 1'b0);
    add_req(OP_SHIFT, COND_AL, ALU_MOV, 32'd0, 1'b1, 1'b0);
    add_req(OP_MOVW, COND_AL, ALU_MOV, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_req(OP_MOVT, COND_AL, ALU_MOV, 32'h1234_5678, 1'b0, 1'b0);
    // transfer offsets: negative, 12-bit max, most negative, masked overflow
    add_req(OP_LDST, COND_AL, ALU_MOV, 32'hFFFF_FFFF, 1'b1, 1'b1);
    add_req(OP_LDST, COND_AL, ALU_MOV, 32'd4095, 1'b0, 1'b0);
    add_req(OP_LDST, COND_AL, ALU_MOV, 32'h8000_0000, 1'b1, 1'b0);
    add_req(OP_LDST, COND_AL, ALU_MOV, 32'd4096, 1'b0, 1'b1);
    add_req(OP_BRANCH, COND_AL, ALU_MOV, 32'd0, 1'b0, 1'b0);
    add_req(OP_BRANCH, COND_AL, ALU_MOV, 32'h7FFF_FFFF, 1'b1, 1'b0);
    add_req(OP_BRANCH, COND_EQ, ALU_MOV, 32'h8000_0000, 1'b0, 1'b0);
    add_req(OP_BX, COND_AL, ALU_MOV, 32'd0, 1'b0, 1'b0);
    add_req(OP_BX, COND_AL, ALU_MOV, 32'd0, 1'b1, 1'b0);
    add_req(OP_MUL, COND_AL, ALU_MOV, 32'd0, 1'b0, 1'b0);
    add_req(OP_SWI, COND_NV, ALU_MOV, 32'd0, 1'b0, 1'b0);
    add_req(OP_UNUSED_LO, COND_AL, ALU_MOV, 32'd0, 1'b0, 1'b0);
    add_req(OP_UNUSED_HI, COND_AL, ALU_MOV, 32'd0, 1'b0, 1'b0);

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    wait_drained();

    // random traffic in chunks; sender holds off until each chunk drains
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        pending_reqs.push_back(rand_req());
        n_queued++;
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_fail == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
